// ===== rtl/asfe_pkg.sv =====
// shared types and constants of the led strip frame engine
`timescale 1ns / 1ps
package asfe_pkg;

  localparam int OPC_W      = 4;
  localparam int PIX_W      = 6;
  localparam int CH_W       = 8;
  localparam int COL_W      = 3 * CH_W;
  localparam int CODE_W     = 8 * CH_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CH_W-1:0] ONE_SYM_RST  = 8'd248;
  localparam logic [CH_W-1:0] ZERO_SYM_RST = 8'd192;

  typedef enum logic [OPC_W-1:0] {
    OP_SET_LED     = 4'd0,
    OP_SET_ALL     = 4'd1,
    OP_LED_BRIGHT  = 4'd2,
    OP_ALL_BRIGHT  = 4'd3,
    OP_DIM         = 4'd4,
    OP_SHIFT_UP    = 4'd5,
    OP_SHIFT_DOWN  = 4'd6,
    OP_REFRESH     = 4'd7,
    OP_READ        = 4'd8
  } asfe_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_SYM  = 1'b0,
    CFG_ZERO_SYM = 1'b1
  } asfe_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_MUL,
    S_EMIT
  } asfe_state_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [PIX_W-1:0] led_index;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  amount;
  } asfe_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_number;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [CH_W-1:0]   brightness_out;
    logic [CODE_W-1:0] green_code;
    logic [CODE_W-1:0] red_code;
    logic [CODE_W-1:0] blue_code;
    logic              last_pixel;
  } asfe_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic mul;
    logic emit;
    logic cnt_inc;
  } asfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic emit_op;
    logic last_iter;
    logic out_free;
  } asfe_sts_t;

endpackage

// ===== rtl/asfe_in_if.sv =====
// command channel of the led strip frame engine
`timescale 1ns / 1ps
interface asfe_in_if;
  import asfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [PIX_W-1:0]  led_index;
  logic [CH_W-1:0]   red_in;
  logic [CH_W-1:0]   green_in;
  logic [CH_W-1:0]   blue_in;
  logic [CH_W-1:0]   amount;

  modport source (
    output valid, opcode, led_index, red_in, green_in, blue_in, amount,
    input  ready
  );

  modport sink (
    input  valid, opcode, led_index, red_in, green_in, blue_in, amount,
    output ready
  );

endinterface

// ===== rtl/asfe_out_if.sv =====
// pixel result channel of the led strip frame engine
`timescale 1ns / 1ps
interface asfe_out_if;
  import asfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_number;
  logic [CH_W-1:0]   red_out;
  logic [CH_W-1:0]   green_out;
  logic [CH_W-1:0]   blue_out;
  logic [CH_W-1:0]   brightness_out;
  logic [CODE_W-1:0] green_code;
  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] blue_code;
  logic              last_pixel;

  modport source (
    output valid, pixel_number, red_out, green_out, blue_out, brightness_out,
           green_code, red_code, blue_code, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_number, red_out, green_out, blue_out, brightness_out,
           green_code, red_code, blue_code, last_pixel,
    output ready
  );

endinterface

// ===== rtl/asfe_ctrl.sv =====
// sequencing state machine of the led strip frame engine
`timescale 1ns / 1ps
module asfe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output asfe_pkg::asfe_cmd_t  cmd,
  input  asfe_pkg::asfe_sts_t  sts
);
  import asfe_pkg::*;

  asfe_state_t state_r;
  asfe_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        priority if (sts.skip) begin
          state_nxt = S_IDLE;
        end else if (sts.emit_op) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        state_nxt = sts.last_iter ? S_IDLE : S_RD;
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_iter ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RD: begin
        cmd.rd = 1'b1;
      end
      S_WR: begin
        cmd.wr      = 1'b1;
        cmd.cnt_inc = !sts.last_iter;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_EMIT: begin
        cmd.emit    = sts.out_free;
        cmd.cnt_inc = sts.out_free && !sts.last_iter;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTH
  // one command at a time: no second word right after an accepted one
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted back to back");

  // a pixel is only pushed into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");
`endif

endmodule

// ===== rtl/asfe_dp.sv =====
// stores, scaling and symbol coding of the led strip frame engine
`timescale 1ns / 1ps
module asfe_dp #(
  parameter int STRIP_LENGTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [asfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  asfe_pkg::asfe_in_t               in_word,
  input  asfe_pkg::asfe_cmd_t              cmd,
  output asfe_pkg::asfe_sts_t              sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output asfe_pkg::asfe_out_t              out_word
);
  import asfe_pkg::*;

  localparam int AW = $clog2(STRIP_LENGTH);
  localparam int CW = $clog2(STRIP_LENGTH + 1);
  localparam logic [CW-1:0]  LAST_ALL   = CW'(STRIP_LENGTH - 1);
  localparam logic [CW-1:0]  LAST_SHIFT = CW'(STRIP_LENGTH - 2);
  localparam logic [PIX_W:0] LEN_PIX    = (PIX_W + 1)'(STRIP_LENGTH);
  localparam logic [AW:0]    LEN_ADDR   = (AW + 1)'(STRIP_LENGTH);

  function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                               input logic [CH_W-1:0] b);
    logic [2*CH_W:0] p;
    p = (2*CH_W+1)'(c) * ((2*CH_W+1)'(b) + (2*CH_W+1)'(1));
    return p[2*CH_W-1:CH_W];
  endfunction

  // msb symbol lands in the top byte
  function automatic logic [CODE_W-1:0] sym_code(input logic [CH_W-1:0] v,
                                                 input logic [CH_W-1:0] one_sym,
                                                 input logic [CH_W-1:0] zero_sym);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int k = 0; k < CH_W; k++) begin
      code[CH_W*k +: CH_W] = v[k] ? one_sym : zero_sym;
    end
    return code;
  endfunction

  logic [CH_W-1:0]  one_sym_r;
  logic [CH_W-1:0]  zero_sym_r;

  logic [OPC_W-1:0] op_r;
  logic [PIX_W-1:0] idx_r;
  logic [COL_W-1:0] col_r;
  logic [CH_W-1:0]  amt_r;
  logic [CW-1:0]    cnt_r;

  logic [COL_W-1:0] cmem [STRIP_LENGTH];
  logic [CH_W-1:0]  bmem [STRIP_LENGTH];
  logic [STRIP_LENGTH-1:0] cval_r;
  logic [STRIP_LENGTH-1:0] bval_r;

  logic [COL_W-1:0] crd_r;
  logic [CH_W-1:0]  brd_r;
  logic             crdv_r;
  logic             brdv_r;

  logic [CH_W-1:0]  sr_r;
  logic [CH_W-1:0]  sg_r;
  logic [CH_W-1:0]  sb_r;

  logic             out_valid_r;
  asfe_out_t        out_r;

  asfe_op_t         op;
  logic             in_range;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    wa;
  logic [CW-1:0]    last_cnt;
  logic [CW-1:0]    cnt_up;
  logic [CW-1:0]    cnt_up_m1;
  logic [CW-1:0]    cnt_nx;
  logic             skip;
  logic             emit_op;
  logic             stored;
  logic             cwe;
  logic             bwe;
  logic [COL_W-1:0] cwd;
  logic [CH_W-1:0]  bwd;
  logic [COL_W-1:0] ceff;
  logic [CH_W-1:0]  beff;
  logic [CH_W-1:0]  dimmed;
  logic             last_iter;
  logic             out_free;

  // never-written entries read as zero
  assign ceff   = crdv_r ? crd_r : '0;
  assign beff   = brdv_r ? brd_r : '0;
  assign dimmed = (beff > amt_r) ? (beff - amt_r) : '0;

  assign op        = asfe_op_t'(op_r);
  assign in_range  = {1'b0, idx_r} < LEN_PIX;
  assign cnt_up    = LAST_ALL - cnt_r;
  assign cnt_up_m1 = cnt_up - CW'(1);
  assign cnt_nx    = cnt_r + CW'(1);

  always_comb begin
    ra       = idx_r[AW-1:0];
    wa       = idx_r[AW-1:0];
    last_cnt = '0;
    skip     = 1'b0;
    emit_op  = 1'b0;
    stored   = 1'b0;
    cwe      = 1'b0;
    bwe      = 1'b0;
    cwd      = col_r;
    bwd      = amt_r;
    unique case (op)
      OP_SET_LED: begin
        skip = !in_range;
        cwe  = 1'b1;
      end
      OP_SET_ALL: begin
        ra       = cnt_r[AW-1:0];
        wa       = cnt_r[AW-1:0];
        last_cnt = LAST_ALL;
        cwe      = 1'b1;
      end
      OP_LED_BRIGHT: begin
        skip = !in_range;
        bwe  = 1'b1;
      end
      OP_ALL_BRIGHT: begin
        ra       = cnt_r[AW-1:0];
        wa       = cnt_r[AW-1:0];
        last_cnt = LAST_ALL;
        bwe      = 1'b1;
      end
      OP_DIM: begin
        ra       = cnt_r[AW-1:0];
        wa       = cnt_r[AW-1:0];
        last_cnt = LAST_ALL;
        bwe      = 1'b1;
        bwd      = dimmed;
      end
      OP_SHIFT_UP: begin
        // walk from the top down so each source is read before it is overwritten
        ra       = cnt_up_m1[AW-1:0];
        wa       = cnt_up[AW-1:0];
        last_cnt = LAST_SHIFT;
        cwe      = 1'b1;
        cwd      = ceff;
      end
      OP_SHIFT_DOWN: begin
        ra       = cnt_nx[AW-1:0];
        wa       = cnt_r[AW-1:0];
        last_cnt = LAST_SHIFT;
        cwe      = 1'b1;
        cwd      = ceff;
      end
      OP_REFRESH: begin
        ra       = cnt_r[AW-1:0];
        wa       = cnt_r[AW-1:0];
        last_cnt = LAST_ALL;
        emit_op  = 1'b1;
      end
      OP_READ: begin
        skip    = !in_range;
        emit_op = 1'b1;
        stored  = 1'b1;
      end
      default: begin
        skip = 1'b1;
      end
    endcase
  end

  assign last_iter = (cnt_r == last_cnt);
  assign out_free  = !out_valid_r || out_ready;

  assign sts.skip      = skip;
  assign sts.emit_op   = emit_op;
  assign sts.last_iter = last_iter;
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_sym_r  <= ONE_SYM_RST;
      zero_sym_r <= ZERO_SYM_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ONE_SYM) begin
        one_sym_r <= cfg_data;
      end else if (cfg_index == CFG_ZERO_SYM) begin
        zero_sym_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cval_r      <= '0;
      bval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_nx;
      end
      if (cmd.wr && cwe) begin
        cval_r[wa] <= 1'b1;
      end
      if (cmd.wr && bwe) begin
        bval_r[wa] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_word.opcode;
      idx_r <= in_word.led_index;
      col_r <= {in_word.red_in, in_word.green_in, in_word.blue_in};
      amt_r <= in_word.amount;
    end
  end

  // colour and brightness stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr && cwe) begin
      cmem[wa] <= cwd;
    end
    if (cmd.rd) begin
      crd_r  <= cmem[ra];
      crdv_r <= cval_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && bwe) begin
      bmem[wa] <= bwd;
    end
    if (cmd.rd) begin
      brd_r  <= bmem[ra];
      brdv_r <= bval_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sr_r <= scale_ch(ceff[3*CH_W-1:2*CH_W], beff);
      sg_r <= scale_ch(ceff[2*CH_W-1:CH_W], beff);
      sb_r <= scale_ch(ceff[CH_W-1:0], beff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.pixel_number   <= PIX_W'(ra);
      out_r.red_out        <= stored ? ceff[3*CH_W-1:2*CH_W] : sr_r;
      out_r.green_out      <= stored ? ceff[2*CH_W-1:CH_W] : sg_r;
      out_r.blue_out       <= stored ? ceff[CH_W-1:0] : sb_r;
      out_r.brightness_out <= beff;
      out_r.green_code     <= sym_code(sg_r, one_sym_r, zero_sym_r);
      out_r.red_code       <= sym_code(sr_r, one_sym_r, zero_sym_r);
      out_r.blue_code      <= sym_code(sb_r, one_sym_r, zero_sym_r);
      out_r.last_pixel     <= last_iter;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTH
  // every store write lands inside the strip
  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && (cwe || bwe)) |-> ({1'b0, wa} < LEN_ADDR))
    else $error("store write beyond strip");

  // the walk counter stays within the strip
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_ALL)
    else $error("walk counter overran");
`endif

endmodule

// ===== rtl/argb_strip_frame_engine.sv =====
// top level of the led strip frame engine
// single set commands: a read state, then a write state, then ready again; an index beyond the strip skips the write
// set all, brightness all, dim and shifts: a read, then a write per store entry
// refresh: each led passes the read port, the scale multipliers and the output register,
// and can stall on the sink; read back likewise gives one pixel
// synchronous active-low reset: stores read as zero, symbols return to 248 and 192
`timescale 1ns / 1ps
module argb_strip_frame_engine #(
  parameter int STRIP_LENGTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  asfe_in_if.sink                          in_ch,
  asfe_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [asfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import asfe_pkg::*;

  asfe_in_t  in_word;
  asfe_out_t out_word;
  asfe_cmd_t cmd;
  asfe_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  assign in_word.opcode    = in_ch.opcode;
  assign in_word.led_index = in_ch.led_index;
  assign in_word.red_in    = in_ch.red_in;
  assign in_word.green_in  = in_ch.green_in;
  assign in_word.blue_in   = in_ch.blue_in;
  assign in_word.amount    = in_ch.amount;
  assign in_ch.ready       = in_ready;

  asfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  asfe_dp #(
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.pixel_number   = out_word.pixel_number;
  assign out_ch.red_out        = out_word.red_out;
  assign out_ch.green_out      = out_word.green_out;
  assign out_ch.blue_out       = out_word.blue_out;
  assign out_ch.brightness_out = out_word.brightness_out;
  assign out_ch.green_code     = out_word.green_code;
  assign out_ch.red_code       = out_word.red_code;
  assign out_ch.blue_code      = out_word.blue_code;
  assign out_ch.last_pixel     = out_word.last_pixel;

endmodule
